// ===== rtl/ufbd_pkg.sv =====
// Shared types and constants for the UART fractional baud divisor.
// Used by every module of the block; depends on nothing.
package ufbd_pkg;

  localparam int RefW   = 27;
  localparam int BaudW  = 27;
  localparam int WholeW = 16;
  localparam int FracW  = 4;
  localparam int StatW  = 2;
  localparam int DenW   = BaudW + 1;
  localparam int NumW   = BaudW + 2;
  localparam int Latency = NumW + 2;

  localparam logic [RefW-1:0] RefClockReset = RefW'(3686400);
  localparam logic [NumW-1:0] DivMax = NumW'({WholeW + FracW{1'b1}});

  localparam logic KindToDivisor = 1'b0;
  localparam logic KindToBaud    = 1'b1;

  typedef enum logic [StatW-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic kind;
    logic zero;
  } tag_t;

  typedef struct packed {
    logic            valid;
    tag_t            tag;
    logic [NumW-1:0] nq;
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
  } div_beat_t;

endpackage

// ===== rtl/ufbd_prep.sv =====
// Operand stage: forms numerator and denominator for either conversion.
// Depends on ufbd_pkg.
module ufbd_prep (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      kind,
  input  logic [ufbd_pkg::BaudW-1:0]  baud_rate,
  input  logic [ufbd_pkg::WholeW-1:0] divisor_whole,
  input  logic [ufbd_pkg::FracW-1:0]  divisor_sixteenths,
  input  logic [ufbd_pkg::RefW-1:0]   ref_clock_hz,
  output ufbd_pkg::div_beat_t       beat
);
  import ufbd_pkg::*;

  logic [NumW-1:0] num_next;
  logic [DenW-1:0] den_next;
  logic            zero_next;

  always_comb begin
    if (kind == KindToDivisor) begin
      num_next  = {1'b0, ref_clock_hz, 1'b0} + {2'b00, baud_rate};
      den_next  = {baud_rate, 1'b0};
      zero_next = (baud_rate == '0);
    end else begin
      num_next  = {2'b00, ref_clock_hz};
      den_next  = {{(DenW - WholeW - FracW){1'b0}}, divisor_whole, divisor_sixteenths};
      zero_next = (divisor_whole == '0) && (divisor_sixteenths == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else begin
      beat.valid <= accept;
    end
    beat.tag.kind <= kind;
    beat.tag.zero <= zero_next;
    beat.nq       <= num_next;
    beat.rem      <= '0;
    beat.den      <= den_next;
  end

endmodule

// ===== rtl/ufbd_div_stage.sv =====
// One restoring-division stage: retires one quotient bit per beat.
// Depends on ufbd_pkg.
module ufbd_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  ufbd_pkg::div_beat_t in_beat,
  output ufbd_pkg::div_beat_t out_beat
);
  import ufbd_pkg::*;

  logic [NumW-1:0] shifted;
  logic [NumW:0]   diff;
  logic            ge;

  assign shifted = {in_beat.rem[NumW-2:0], in_beat.nq[NumW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, in_beat.den};
  assign ge      = ~diff[NumW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else begin
      out_beat.valid <= in_beat.valid;
    end
    out_beat.tag <= in_beat.tag;
    out_beat.nq  <= {in_beat.nq[NumW-2:0], ge};
    out_beat.rem <= ge ? diff[NumW-1:0] : shifted;
    out_beat.den <= in_beat.den;
  end

endmodule

// ===== rtl/ufbd_finish.sv =====
// Result stage: splits, saturates and flags the quotient, drives the strobe.
// Depends on ufbd_pkg.
module ufbd_finish (
  input  logic                        clk,
  input  logic                        rst,
  input  ufbd_pkg::div_beat_t         in_beat,
  output logic                        done,
  output logic [ufbd_pkg::WholeW-1:0] result_whole,
  output logic [ufbd_pkg::FracW-1:0]  result_sixteenths,
  output logic [ufbd_pkg::BaudW-1:0]  result_baud,
  output logic [ufbd_pkg::StatW-1:0]  status
);
  import ufbd_pkg::*;

  logic [WholeW-1:0] whole_next;
  logic [FracW-1:0]  frac_next;
  logic [BaudW-1:0]  baud_next;
  status_t           status_next;

  always_comb begin
    whole_next  = '0;
    frac_next   = '0;
    baud_next   = '0;
    status_next = STATUS_OK;
    if (in_beat.tag.zero) begin
      status_next = STATUS_ZERO;
    end else if (in_beat.tag.kind == KindToDivisor) begin
      if (in_beat.nq > DivMax) begin
        whole_next  = '1;
        frac_next   = '1;
        status_next = STATUS_SAT;
      end else begin
        whole_next = in_beat.nq[WholeW+FracW-1:FracW];
        frac_next  = in_beat.nq[FracW-1:0];
      end
    end else begin
      baud_next = in_beat.nq[BaudW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_beat.valid;
    end
    result_whole      <= whole_next;
    result_sixteenths <= frac_next;
    result_baud       <= baud_next;
    status            <= status_next;
  end

endmodule

// ===== rtl/uart_fractional_baud_divisor_top.sv =====
// UART fractional baud divisor: converts baud rate to a 16x divisor and back.
// Depends on ufbd_pkg, ufbd_prep, ufbd_div_stage and ufbd_finish.
//
// A request is taken on any cycle where start is high and busy is low; busy
// is set by rst and clears at the first edge where rst is low. Each request
// yields exactly one result, shown for one cycle with done high, after one
// operand stage, a 29-stage restoring divider that retires one quotient bit
// per stage, and one result stage. While busy is low a new request may enter
// every cycle; results leave in request order; the receiver must take them
// as they come. ref_clock_hz is written through cfg_wr_en and cfg_wr_data
// and must only change while no request is in flight.
module uart_fractional_baud_divisor_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind,
  input  logic [ufbd_pkg::BaudW-1:0]  baud_rate,
  input  logic [ufbd_pkg::WholeW-1:0] divisor_whole,
  input  logic [ufbd_pkg::FracW-1:0]  divisor_sixteenths,
  input  logic                        cfg_wr_en,
  input  logic [ufbd_pkg::RefW-1:0]   cfg_wr_data,
  output logic                        done,
  output logic [ufbd_pkg::WholeW-1:0] result_whole,
  output logic [ufbd_pkg::FracW-1:0]  result_sixteenths,
  output logic [ufbd_pkg::BaudW-1:0]  result_baud,
  output logic [ufbd_pkg::StatW-1:0]  status
);
  import ufbd_pkg::*;

  logic [RefW-1:0] ref_clock_hz;
  div_beat_t       stage_beat [0:NumW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      ref_clock_hz <= RefClockReset;
    end else begin
      busy <= 1'b0;
      if (cfg_wr_en) begin
        ref_clock_hz <= cfg_wr_data;
      end
    end
  end

  ufbd_prep u_prep (
    .clk                (clk),
    .rst                (rst),
    .accept             (start && !busy),
    .kind               (kind),
    .baud_rate          (baud_rate),
    .divisor_whole      (divisor_whole),
    .divisor_sixteenths (divisor_sixteenths),
    .ref_clock_hz       (ref_clock_hz),
    .beat               (stage_beat[0])
  );

  for (genvar i = 0; i < NumW; i++) begin : g_div
    ufbd_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_beat  (stage_beat[i]),
      .out_beat (stage_beat[i+1])
    );
  end

  ufbd_finish u_finish (
    .clk               (clk),
    .rst               (rst),
    .in_beat           (stage_beat[NumW]),
    .done              (done),
    .result_whole      (result_whole),
    .result_sixteenths (result_sixteenths),
    .result_baud       (result_baud),
    .status            (status)
  );

endmodule

// ===== rtl/ufbd_checker.sv =====
// Port-level checks for the UART fractional baud divisor, bound to the top.
// Depends on ufbd_pkg and uart_fractional_baud_divisor_top.
module ufbd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        kind,
  input logic                        done,
  input logic [ufbd_pkg::WholeW-1:0] result_whole,
  input logic [ufbd_pkg::FracW-1:0]  result_sixteenths,
  input logic [ufbd_pkg::BaudW-1:0]  result_baud,
  input logic [ufbd_pkg::StatW-1:0]  status
);
  import ufbd_pkg::*;

  a_beat_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(Latency) done)
    else $error("accepted beat did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result without a matching accepted beat");

  a_sat_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_SAT) |->
      (result_whole == '1 && result_sixteenths == '1 && result_baud == '0))
    else $error("saturated result fields wrong");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_ZERO) |->
      (result_whole == '0 && result_sixteenths == '0 && result_baud == '0))
    else $error("zero-operand result fields not cleared");

  a_baud_kind: assert property (@(posedge clk) disable iff (rst)
    (done && $past(kind, Latency) == KindToBaud) |->
      (result_whole == '0 && result_sixteenths == '0 && status != STATUS_SAT))
    else $error("baud conversion drove divisor fields");

endmodule

bind uart_fractional_baud_divisor_top ufbd_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for uart_fractional_baud_divisor_top: baud-to-divisor and divisor-to-baud beats
// checked against an in-bench predictor across several reference clock settings.
// Depends on ufbd_pkg and the RTL of uart_fractional_baud_divisor_top.
`timescale 1ns / 1ps

module tb;
  import ufbd_pkg::*;

  localparam int StallLimit = 1000;
  localparam logic [BaudW-1:0] BaudFieldMax = {BaudW{1'b1}};

  typedef struct packed {
    logic              kind;
    logic [BaudW-1:0]  baud_rate;
    logic [WholeW-1:0] divisor_whole;
    logic [FracW-1:0]  divisor_sixteenths;
  } conv_req_t;

  typedef struct packed {
    logic [WholeW-1:0] whole;
    logic [FracW-1:0]  sixteenths;
    logic [BaudW-1:0]  baud;
    status_t           st;
  } conv_result_t;

  typedef enum logic [1:0] {
    ACT_CONV,
    ACT_REF_WRITE,
    ACT_DRAIN
  } action_e;

  typedef struct {
    action_e          act;
    conv_req_t        req;
    logic [RefW-1:0]  hz;
  } plan_entry_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              kind;
  logic [BaudW-1:0]  baud_rate;
  logic [WholeW-1:0] divisor_whole;
  logic [FracW-1:0]  divisor_sixteenths;
  logic              cfg_wr_en;
  logic [RefW-1:0]   cfg_wr_data;
  logic              done;
  logic [WholeW-1:0] result_whole;
  logic [FracW-1:0]  result_sixteenths;
  logic [BaudW-1:0]  result_baud;
  logic [StatW-1:0]  status;

  plan_entry_t  plan_q[$];
  conv_result_t expected_conv_q[$];

  logic [RefW-1:0] model_ref_hz = RefClockReset;
  logic            beat_taken = 1'b0;
  int              errors = 0;
  int              idle_cycles = 0;
  int              burst_left = 0;
  int              gap_left = 0;
  int              n_to_divisor = 0;
  int              n_to_baud = 0;
  int              n_saturated = 0;
  int              n_zero = 0;
  int              n_ref_writes = 0;

  uart_fractional_baud_divisor_top DUT (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .kind               (kind),
    .baud_rate          (baud_rate),
    .divisor_whole      (divisor_whole),
    .divisor_sixteenths (divisor_sixteenths),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .done               (done),
    .result_whole       (result_whole),
    .result_sixteenths  (result_sixteenths),
    .result_baud        (result_baud),
    .status             (status)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic conv_result_t predict_conversion(conv_req_t rq, logic [RefW-1:0] hz);
    longint unsigned r;
    longint unsigned b;
    longint unsigned den;
    longint unsigned whole;
    longint unsigned rem;
    longint unsigned frac;
    longint unsigned d16;
    conv_result_t    res;
    r = hz;
    b = rq.baud_rate;
    res.whole = '0;
    res.sixteenths = '0;
    res.baud = '0;
    res.st = STATUS_OK;
    if (rq.kind == KindToDivisor) begin
      if (b == 0) begin
        res.st = STATUS_ZERO;
      end else begin
        den = 16 * b;
        whole = r / den;
        rem = r % den;
        frac = (2 * rem + b) / (2 * b);
        if (frac >= 16) begin
          frac = frac - 16;
          whole = whole + 1;
        end
        if (whole > 65535) begin
          res.whole = '1;
          res.sixteenths = '1;
          res.st = STATUS_SAT;
        end else begin
          res.whole = WholeW'(whole);
          res.sixteenths = FracW'(frac);
        end
      end
    end else begin
      d16 = longint'(rq.divisor_whole) * 16 + rq.divisor_sixteenths;
      if (d16 == 0) begin
        res.st = STATUS_ZERO;
      end else begin
        res.baud = BaudW'(r / d16);
      end
    end
    return res;
  endfunction

  function automatic conv_req_t random_conv_req(logic [RefW-1:0] hz);
    conv_req_t rq;
    int unsigned d;
    int unsigned pick;
    rq.kind = 1'($urandom_range(0, 1));
    d = $urandom_range(1, 4096);
    pick = $urandom_range(0, 19);
    if (pick == 0) rq.baud_rate = '0;
    else if (pick < 4) rq.baud_rate = BaudW'($urandom_range(1, 16));
    else if (pick < 10) rq.baud_rate = BaudW'(hz / (16 * d) + $urandom_range(0, 2));
    else if (pick < 15) rq.baud_rate = BaudW'($urandom());
    else if (pick < 18) rq.baud_rate = BaudW'($urandom_range(1, 100000000));
    else rq.baud_rate = BaudFieldMax - BaudW'($urandom_range(0, 3));
    if (rq.baud_rate == 0 && pick != 0) rq.baud_rate = 1;
    pick = $urandom_range(0, 9);
    if (pick < 5) rq.divisor_whole = WholeW'($urandom());
    else if (pick < 8) rq.divisor_whole = WholeW'($urandom_range(0, 3));
    else if (pick < 9) rq.divisor_whole = WholeW'($urandom_range(0, 300));
    else rq.divisor_whole = '1;
    rq.divisor_sixteenths = FracW'($urandom());
    return rq;
  endfunction

  task automatic add_conv(logic k, logic [BaudW-1:0] b, logic [WholeW-1:0] w,
                          logic [FracW-1:0] f);
    plan_entry_t e;
    e.act = ACT_CONV;
    e.req = '{kind: k, baud_rate: b, divisor_whole: w, divisor_sixteenths: f};
    e.hz = '0;
    plan_q.push_back(e);
  endtask

  task automatic add_plan_marker(action_e act, logic [RefW-1:0] hz);
    plan_entry_t e;
    e.act = act;
    e.req = '0;
    e.hz = hz;
    plan_q.push_back(e);
  endtask

  task automatic add_random_phase(int n, logic [RefW-1:0] hz);
    plan_entry_t e;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) add_plan_marker(ACT_DRAIN, '0);
      e.act = ACT_CONV;
      e.req = random_conv_req(hz);
      e.hz = '0;
      plan_q.push_back(e);
    end
  endtask

  // driver: present beats at the falling edge, hold start until taken
  always @(negedge clk) begin
    logic nx_start;
    logic nx_cfg;
    nx_start = start;
    nx_cfg = 1'b0;
    if (rst) begin
      nx_start = 1'b0;
    end else if (!(start && !beat_taken)) begin
      nx_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (plan_q.size() > 0) begin
        case (plan_q[0].act)
          ACT_CONV: begin
            nx_start = 1'b1;
            kind <= plan_q[0].req.kind;
            baud_rate <= plan_q[0].req.baud_rate;
            divisor_whole <= plan_q[0].req.divisor_whole;
            divisor_sixteenths <= plan_q[0].req.divisor_sixteenths;
            void'(plan_q.pop_front());
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 60);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
          ACT_REF_WRITE: begin
            if (expected_conv_q.size() == 0 && !cfg_wr_en) begin
              nx_cfg = 1'b1;
              cfg_wr_data <= plan_q[0].hz;
              void'(plan_q.pop_front());
            end
          end
          default: begin
            if (expected_conv_q.size() == 0) void'(plan_q.pop_front());
          end
        endcase
      end
    end
    start <= nx_start;
    cfg_wr_en <= nx_cfg;
  end

  // monitor: sample at the rising edge, predict taken beats, check results
  always @(posedge clk) begin
    conv_req_t    rq;
    conv_result_t want;
    if (rst) begin
      beat_taken = 1'b0;
    end else begin
      beat_taken = start && !busy;
      if (cfg_wr_en) begin
        model_ref_hz = cfg_wr_data;
        n_ref_writes++;
      end
      if (beat_taken) begin
        rq = '{kind: kind, baud_rate: baud_rate, divisor_whole: divisor_whole,
               divisor_sixteenths: divisor_sixteenths};
        want = predict_conversion(rq, model_ref_hz);
        expected_conv_q.push_back(want);
        if (rq.kind == KindToDivisor) n_to_divisor++;
        else n_to_baud++;
        if (want.st == STATUS_SAT) n_saturated++;
        if (want.st == STATUS_ZERO) n_zero++;
      end
      if (done) begin
        if (expected_conv_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = expected_conv_q.pop_front();
          if (result_whole !== want.whole) begin
            $error("result_whole: expected %0d, got %0d", want.whole, result_whole);
            errors++;
          end
          if (result_sixteenths !== want.sixteenths) begin
            $error("result_sixteenths: expected %0d, got %0d", want.sixteenths,
                   result_sixteenths);
            errors++;
          end
          if (result_baud !== want.baud) begin
            $error("result_baud: expected %0d, got %0d", want.baud, result_baud);
            errors++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors++;
          end
        end
      end
      if (beat_taken || done || cfg_wr_en) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no beat moved for %0d cycles", StallLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [RefW-1:0] ref_plan[$];
    rst = 1'b1;
    start = 1'b0;
    kind = KindToDivisor;
    baud_rate = '0;
    divisor_whole = '0;
    divisor_sixteenths = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;

    // directed beats at the reset reference clock
    add_conv(KindToDivisor, 0, 16'hFFFF, 4'hF);
    add_conv(KindToDivisor, 1, 0, 0);
    add_conv(KindToDivisor, 3, 0, 0);
    add_conv(KindToDivisor, 4, 0, 0);
    add_conv(KindToDivisor, 9600, 0, 0);
    add_conv(KindToDivisor, 115200, 0, 0);
    add_conv(KindToDivisor, 230400, 0, 0);
    add_conv(KindToDivisor, 230401, 0, 0);
    add_conv(KindToDivisor, 100000, 16'h1234, 4'h5);
    add_conv(KindToDivisor, 100000000, 0, 0);
    add_conv(KindToDivisor, BaudFieldMax, 16'hFFFF, 4'hF);
    add_conv(KindToDivisor, 27'h5555555, 0, 0);
    add_conv(KindToDivisor, 27'h2AAAAAA, 0, 0);
    add_conv(KindToBaud, BaudFieldMax, 0, 0);
    add_conv(KindToBaud, 0, 0, 1);
    add_conv(KindToBaud, 0, 0, 4'hF);
    add_conv(KindToBaud, 0, 1, 0);
    add_conv(KindToBaud, 0, 2, 0);
    add_conv(KindToBaud, 0, 16'hFFFF, 0);
    add_conv(KindToBaud, 0, 16'hFFFF, 4'hF);
    add_conv(KindToBaud, 27'h1234567, 16'h5555, 4'hA);
    add_conv(KindToBaud, 0, 16'hAAAA, 4'h5);
    add_random_phase(338, RefClockReset);

    ref_plan = '{RefW'(1), RefW'(100000000), RefW'(0), RefW'({RefW{1'b1}}),
                 RefW'(48000000), RefW'($urandom_range(1, 100000000)), RefClockReset};
    foreach (ref_plan[i]) begin
      add_plan_marker(ACT_REF_WRITE, ref_plan[i]);
      add_random_phase((ref_plan[i] == 0) ? 150 : 240, ref_plan[i]);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    do @(posedge clk);
    while (plan_q.size() > 0 || start || expected_conv_q.size() > 0);
    repeat (Latency + 8) @(posedge clk);

    $display("Covered %0d baud-to-divisor and %0d divisor-to-baud beats over %0d clock writes",
             n_to_divisor, n_to_baud, n_ref_writes);
    $display("Saturated divisors: %0d, zero inputs: %0d", n_saturated, n_zero);
    if (errors == 0 && expected_conv_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ufbd_pkg.sv
rtl/ufbd_prep.sv
rtl/ufbd_div_stage.sv
rtl/ufbd_finish.sv
rtl/uart_fractional_baud_divisor_top.sv
rtl/ufbd_checker.sv
tb/sv/tb.sv
